FILE: rtl/assert_macros.svh
// Assertion macros shared by the flame detector RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, off while reset is asserted.
`define IFD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Plain condition checked at every rising edge, off while reset is asserted.
`define IFD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

FILE: rtl/ifd_pkg.sv
// Types and constants for the IR flame detector with direction estimate.
// No dependencies.
`default_nettype none

package ifd_pkg;

    // Channel count and sample width; the request structs below fix them.
    localparam int NUM_CH   = 5;
    localparam int SAMPLE_W = 12;

    // Configuration register widths and indexes.
    localparam int THR_W   = 12;
    localparam int OFF_W   = 8;
    localparam int ANG_W   = 9;
    localparam int CFG_W   = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_THRESHOLD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELATIVE_OFFSET_PCT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DETECTION_ANGLE     = 2'd2;

    localparam logic [THR_W-1:0] THR_RESET = 12'd2048;
    localparam logic [OFF_W-1:0] OFF_RESET = 8'd20;
    localparam logic [ANG_W-1:0] ANG_RESET = 9'd180;

    // Datapath widths.
    localparam int SUM_W  = 15;   // sum of five samples
    localparam int PROD_W = 21;   // average * (offset + 100)
    localparam int REL_W  = 14;   // relative threshold
    localparam int REM_W  = 19;   // sample * 100, divider remainder
    localparam int DVS_W  = 22;   // shifted divisor
    localparam int PCT_W  = 8;    // per-channel percentage, below 200
    localparam int WGT_W  = 9;    // angle step times channel index
    localparam int PW_W   = 17;   // percentage times weight
    localparam int ACC_W  = 20;   // weighted sum
    localparam int QD_W   = 11;   // weighted sum / 100
    localparam int DIR_W  = 12;

    // Reciprocal constants for division by 5 and by 25.
    localparam logic [16:0] RECIP5     = 17'd52429;
    localparam int          RECIP5_SH  = 18;
    localparam logic [19:0] RECIP25A   = 20'd671089;
    localparam int          RECIP25A_SH = 24;
    localparam logic [15:0] RECIP25B   = 16'd41944;
    localparam int          RECIP25B_SH = 20;

    // Stage numbering of the pipeline.
    localparam int N_STG     = 14;
    localparam int STG_SUM   = 0;
    localparam int STG_AVG   = 1;
    localparam int STG_PREP  = 2;
    localparam int STG_REL   = 3;
    localparam int STG_FLAME = 4;
    localparam int STG_DIV_LAST = 10;
    localparam int STG_MUL   = 11;
    localparam int STG_ACC   = 12;
    localparam int STG_QD    = 13;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_0;
        logic [SAMPLE_W-1:0] sample_1;
        logic [SAMPLE_W-1:0] sample_2;
        logic [SAMPLE_W-1:0] sample_3;
        logic [SAMPLE_W-1:0] sample_4;
    } in_t;

    typedef struct packed {
        logic                    flame_detected;
        logic signed [DIR_W-1:0] direction;
        logic                    direction_valid;
        logic [SAMPLE_W-1:0]     average;
    } out_t;

    // Everything one request carries down the pipeline.
    typedef struct packed {
        logic [NUM_CH-1:0][SAMPLE_W-1:0] s;
        logic [SUM_W-1:0]                sum;
        logic [SAMPLE_W-1:0]             avg;
        logic [PROD_W-1:0]               prod;
        logic [REL_W-1:0]                rel;
        logic [SUM_W-1:0]                total;
        logic                            dvalid;
        logic                            flame;
        logic [NUM_CH-1:0][REM_W-1:0]    rem;
        logic [NUM_CH-1:0][PCT_W-1:0]    q;
        logic [NUM_CH-1:0][PW_W-1:0]     pw;
        logic [ACC_W-1:0]                acc;
        logic [QD_W-1:0]                 qd;
    } pipe_t;

endpackage

`default_nettype wire

FILE: rtl/ir_flame_detect_direction_unit.sv
// IR flame detector with direction estimate: top level and whole pipeline.
// Depends on ifd_pkg and assert_macros.svh.
`default_nettype none

// One request of five simultaneous IR samples enters per cycle unless
// out_ready stalls the pipeline, and its result passes through 14 pipeline
// stages and the output register; the throughput is one request per cycle,
// held by the eight one-bit stages of the per-channel percentage divider.
// The block keeps no state between requests. Configuration writes are taken
// at any time but must only be made while the pipeline is empty.
module ir_flame_detect_direction_unit
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire ifd_pkg::in_t                    in_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output ifd_pkg::out_t                        out_data,
    input  wire logic                            cfg_we,
    input  wire logic [ifd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ifd_pkg::CFG_W-1:0]       cfg_data
);
    import ifd_pkg::*;

    logic [THR_W-1:0] thr_reg;
    logic [OFF_W-1:0] off_reg;
    logic [ANG_W-1:0] ang_reg;

    pipe_t            st_reg [N_STG];
    pipe_t            st_next [N_STG];
    logic [N_STG-1:0] vld_reg;
    logic [N_STG:0]   rdy;
    pipe_t            in_pipe;
    out_t             out_reg;
    out_t             out_next;
    logic             out_vld_reg;

    // One pipeline step; k selects which stage's work is done.
    function automatic pipe_t stage_fn(input int k, input pipe_t p,
                                       input logic [THR_W-1:0] thr,
                                       input logic [OFF_W-1:0] off,
                                       input logic [ANG_W-1:0] ang);
        pipe_t              r;
        int                 b;
        logic [DVS_W-1:0]   dvs;
        logic [ANG_W-1:0]   step;
        logic [WGT_W-1:0]   wgt;
        logic [ACC_W-1:0]   acc;
        logic [39:0]        wide;
        r = p;
        case (k)
            STG_SUM:
            begin
                r.sum = '0;
                for (int i = 0; i < NUM_CH; i++)
                    r.sum = r.sum + SUM_W'(p.s[i]);
            end
            STG_AVG:
            begin
                // Divide by five through a reciprocal; exact for sums below 20480.
                wide  = 40'(p.sum) * 40'(RECIP5);
                r.avg = SAMPLE_W'(wide >> RECIP5_SH);
            end
            STG_PREP:
            begin
                r.prod   = PROD_W'(p.avg) * (PROD_W'(off) + PROD_W'(100));
                r.total  = SUM_W'(p.avg) * SUM_W'(NUM_CH);
                r.dvalid = (p.avg != '0);
                for (int i = 0; i < NUM_CH; i++)
                begin
                    r.rem[i] = REM_W'(p.s[i]) * REM_W'(100);
                    r.q[i]   = '0;
                end
            end
            STG_FLAME:
            begin
                r.flame = 1'b0;
                for (int i = 0; i < NUM_CH; i++)
                    if (p.s[i] >= thr || REL_W'(p.s[i]) >= p.rel)
                        r.flame = 1'b1;
            end
            STG_MUL:
            begin
                step = ang / ANG_W'(NUM_CH - 1);
                for (int i = 0; i < NUM_CH; i++)
                begin
                    wgt     = WGT_W'(step * ANG_W'(i));
                    r.pw[i] = PW_W'(p.q[i]) * PW_W'(wgt);
                end
            end
            STG_ACC:
            begin
                acc = '0;
                for (int i = 0; i < NUM_CH; i++)
                    acc = acc + ACC_W'(p.pw[i]);
                r.acc = acc;
            end
            STG_QD:
            begin
                // Divide by 100 as a shift by two and a reciprocal of 25.
                wide = 40'(p.acc >> 2) * 40'(RECIP25B);
                r.qd = QD_W'(wide >> RECIP25B_SH);
            end
            default:
            begin
            end
        endcase
        // Relative threshold: product / 100.
        if (k == STG_REL)
        begin
            wide  = 40'(p.prod >> 2) * 40'(RECIP25A);
            r.rel = REL_W'(wide >> RECIP25A_SH);
        end
        // One quotient bit per stage of each channel's percentage divider.
        if (k >= STG_REL && k <= STG_DIV_LAST)
        begin
            b = STG_DIV_LAST - k;
            for (int i = 0; i < NUM_CH; i++)
            begin
                dvs = DVS_W'(p.total) << b;
                if (DVS_W'(p.rem[i]) >= dvs)
                begin
                    r.rem[i]    = p.rem[i] - REM_W'(dvs);
                    r.q[i][b]   = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
            off_reg <= OFF_RESET;
            ang_reg <= ANG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIXED_THRESHOLD:     thr_reg <= cfg_data[THR_W-1:0];
                CFG_RELATIVE_OFFSET_PCT: off_reg <= cfg_data[OFF_W-1:0];
                CFG_DETECTION_ANGLE:     ang_reg <= cfg_data[ANG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Request entering the first stage.
    always_comb
    begin
        in_pipe      = '0;
        in_pipe.s[0] = in_data.sample_0;
        in_pipe.s[1] = in_data.sample_1;
        in_pipe.s[2] = in_data.sample_2;
        in_pipe.s[3] = in_data.sample_3;
        in_pipe.s[4] = in_data.sample_4;
    end

    // Stage logic and per-stage ready: a stage moves when it is empty or
    // the stage after it moves.
    always_comb
    begin
        rdy[N_STG] = !out_vld_reg || out_ready;
        for (int k = N_STG - 1; k >= 0; k--)
            rdy[k] = !vld_reg[k] || rdy[k+1];
        st_next[0] = stage_fn(0, in_pipe, thr_reg, off_reg, ang_reg);
        for (int k = 1; k < N_STG; k++)
            st_next[k] = stage_fn(k, st_reg[k-1], thr_reg, off_reg, ang_reg);
    end

    assign in_ready = rdy[0];

    // Pipeline registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
                vld_reg[0] <= in_valid;
            for (int k = 1; k < N_STG; k++)
                if (rdy[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid)
            st_reg[0] <= st_next[0];
        for (int k = 1; k < N_STG; k++)
            if (rdy[k] && vld_reg[k-1])
                st_reg[k] <= st_next[k];
    end

    // Final direction: (weighted sum / 100 - angle / 2) * 2, or zero.
    always_comb
    begin
        logic signed [DIR_W:0] diff;
        diff = $signed({2'b00, st_reg[N_STG-1].qd})
             - $signed({5'b00000, ang_reg[ANG_W-1:1]});
        out_next.flame_detected  = st_reg[N_STG-1].flame;
        out_next.direction_valid = st_reg[N_STG-1].dvalid;
        out_next.average         = st_reg[N_STG-1].avg;
        out_next.direction       = st_reg[N_STG-1].dvalid
                                 ? DIR_W'(diff <<< 1) : '0;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (rdy[N_STG])
            out_vld_reg <= vld_reg[N_STG-1];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[N_STG] && vld_reg[N_STG-1])
            out_reg <= out_next;
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

`include "assert_macros.svh"

    `IFD_ASSERT_IMPL(a_ready_when_out_empty, !out_vld_reg, in_ready,
        "input not ready although the output register is empty")
    `IFD_ASSERT_IMPL(a_dir_zero_when_invalid, out_valid && !out_data.direction_valid,
        out_data.direction == '0, "direction nonzero without a valid total")
    `IFD_ASSERT_IMPL(a_valid_needs_average, out_valid && out_data.direction_valid,
        out_data.average != '0, "direction valid with a zero average")
    `IFD_ASSERT_ALWAYS(a_ready_chain, !in_ready || rdy[N_STG] || !(&vld_reg) == 1'b1,
        "input ready while every stage is full and the output is stalled")

endmodule

`default_nettype wire
